[sv/mieu_pkg.sv]
// Shared operation codes, types and helpers for the integer execute unit.
`default_nettype none
package mieu_pkg;
    typedef logic [4:0]  t_ridx;
    typedef logic [63:0] t_dword;
    typedef logic [1:0]  t_mdu_op;

    localparam logic [4:0] A_J     = 5'd0;
    localparam logic [4:0] A_JAL   = 5'd1;
    localparam logic [4:0] A_JR    = 5'd2;
    localparam logic [4:0] A_JALR  = 5'd3;
    localparam logic [4:0] A_BEQ   = 5'd4;
    localparam logic [4:0] A_BNE   = 5'd5;
    localparam logic [4:0] A_BLEZ  = 5'd6;
    localparam logic [4:0] A_BGTZ  = 5'd7;
    localparam logic [4:0] A_BLTZ  = 5'd8;
    localparam logic [4:0] A_BGEZ  = 5'd9;
    localparam logic [4:0] A_BEQL  = 5'd10;
    localparam logic [4:0] A_BNEL  = 5'd11;
    localparam logic [4:0] A_ADDIU = 5'd12;
    localparam logic [4:0] A_SLTI  = 5'd13;
    localparam logic [4:0] A_SLTIU = 5'd14;
    localparam logic [4:0] A_ANDI  = 5'd15;
    localparam logic [4:0] A_ORI   = 5'd16;
    localparam logic [4:0] A_LUI   = 5'd17;
    localparam logic [4:0] A_SLL   = 5'd18;
    localparam logic [4:0] A_SRA   = 5'd19;
    localparam logic [4:0] A_MOVN  = 5'd20;
    localparam logic [4:0] A_MFHI  = 5'd21;
    localparam logic [4:0] A_MFLO  = 5'd22;
    localparam logic [4:0] A_MULT  = 5'd23;
    localparam logic [4:0] A_DIV   = 5'd24;
    localparam logic [4:0] A_DIVU  = 5'd25;
    localparam logic [4:0] A_ADDU  = 5'd26;
    localparam logic [4:0] A_SUBU  = 5'd27;
    localparam logic [4:0] A_OR    = 5'd28;
    localparam logic [4:0] A_SLTU  = 5'd29;
    localparam logic [4:0] A_DADDU = 5'd30;

    localparam t_mdu_op M_MULT = 2'd0;
    localparam t_mdu_op M_DIV  = 2'd1;
    localparam t_mdu_op M_DIVU = 2'd2;

    localparam int RegCount = 32;
    localparam logic [31:0] JumpRegionMask = 32'hF000_0000;

    function automatic t_dword sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction
endpackage
`default_nettype wire

[sv/mieu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mieu_ram #(
    parameter int Width = 64,
    parameter int Depth = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[sv/mieu_mdu.sv]
// Iterative radix-2 multiply/divide unit sharing one 34-bit adder.
`default_nettype none
module mieu_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mieu_pkg::t_mdu_op i_op,
    input  wire logic [31:0]       i_a,
    input  wire logic [31:0]       i_b,
    output logic                   o_done,
    output mieu_pkg::t_dword       o_hi,
    output mieu_pkg::t_dword       o_lo
);
    import mieu_pkg::*;

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    t_mdu_op     r_op;
    logic        r_neg_q, r_neg_r, r_dz;
    logic [31:0] r_a, r_opnd;
    logic [64:0] r_acc;

    logic        is_signed;
    logic [31:0] ma, mb;
    logic [33:0] add_x, add_y, sum;
    logic        add_cin;
    logic [64:0] n_acc;
    logic [63:0] prod;
    logic [31:0] quo, rem;

    always_comb begin
        is_signed = (i_op != M_DIVU);
        ma = (is_signed && i_a[31]) ? 32'(-i_a) : i_a;
        mb = (is_signed && i_b[31]) ? 32'(-i_b) : i_b;
    end

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        if (r_op == M_MULT) begin
            add_x   = {1'b0, r_acc[64:32]};
            add_y   = r_acc[0] ? {2'b0, r_opnd} : 34'd0;
            add_cin = 1'b0;
        end else begin
            add_x   = {1'b0, r_acc[63:31]};
            add_y   = ~{2'b0, r_opnd};
            add_cin = 1'b1;
        end
        sum = add_x + add_y + {33'd0, add_cin};
        if (r_op == M_MULT) begin
            n_acc = {1'b0, sum[32:0], r_acc[31:1]};
        end else if (!sum[33]) begin
            n_acc = {1'b0, sum[31:0], r_acc[30:0], 1'b1};
        end else begin
            n_acc = {1'b0, r_acc[62:31], r_acc[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op    <= i_op;
            r_a     <= i_a;
            r_dz    <= (i_b == 32'd0);
            r_neg_q <= is_signed && (i_a[31] ^ i_b[31]);
            r_neg_r <= is_signed && i_a[31];
            if (i_op == M_MULT) begin
                r_opnd <= ma;
                r_acc  <= {33'd0, mb};
            end else begin
                r_opnd <= mb;
                r_acc  <= {33'd0, ma};
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        prod = r_neg_q ? 64'(-r_acc[63:0]) : r_acc[63:0];
        quo  = r_neg_q ? 32'(-r_acc[31:0]) : r_acc[31:0];
        rem  = r_neg_r ? 32'(-r_acc[63:32]) : r_acc[63:32];
        if (r_op == M_MULT) begin
            o_hi = sx32(prod[63:32]);
            o_lo = sx32(prod[31:0]);
        end else if (r_dz) begin
            o_hi = sx32(r_a);
            o_lo = (r_op == M_DIV && r_a[31]) ? 64'd1 : '1;
        end else begin
            o_hi = sx32(rem);
            o_lo = sx32(quo);
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

[sv/mips64_integer_execute_unit.sv]
// Top level: register file, instruction sequencer and result register.
// Sequence: register read on accept, execute in S_EXEC, then the result beat in
// S_OUT; mult/div/divu wait in S_MDU for the 32 steps of the radix-2 unit.
// A new instruction is taken only in S_IDLE, after the last result beat has left.
// Reset (synchronous, active low) clears the sequencer, hi/lo and the
// per-register valid bits, so every general register reads as zero.
`default_nettype none
module mips64_integer_execute_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [4:0]    i_action,
    input  wire logic [4:0]    i_src_a_index,
    input  wire logic [4:0]    i_src_b_index,
    input  wire logic [4:0]    i_dest_index,
    input  wire logic [4:0]    i_shift_amount,
    input  wire logic [15:0]   i_immediate,
    input  wire logic [25:0]   i_jump_target,
    input  wire logic [31:0]   i_current_pc,
    input  wire logic [31:0]   i_sequential_next_pc,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_next_pc,
    output logic               o_branch_taken,
    output logic               o_skip_delay_slot,
    output logic               o_reg_written,
    output logic [4:0]         o_written_index,
    output logic [63:0]        o_written_value
);
    import mieu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MDU  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [RegCount-1:0] r_rvalid;
    t_dword      r_hi, r_lo;
    logic        r_va_ok, r_vb_ok;

    logic [4:0]  r_act, r_rt, r_rd, r_sa;
    logic [15:0] r_imm;
    logic [25:0] r_tgt;
    logic [31:0] r_pc, r_seq;

    logic [31:0] r_npc;
    logic        r_taken, r_skip, r_wr;
    t_ridx       r_widx;
    t_dword      r_wval;

    t_dword      rd_a, rd_b, va, vb;
    logic        accept;

    logic [31:0] a, b, simm, jtarget, btarget, n_npc, sra_v;
    logic        n_taken, n_skip, n_wr, cond;
    t_ridx       n_widx;
    t_dword      n_wval;
    logic        is_mdu, rf_we;
    t_ridx       rf_widx;
    t_dword      rf_wval;
    t_mdu_op     mdu_op;
    logic        mdu_done;
    t_dword      mdu_hi, mdu_lo;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    mieu_ram #(.Width(64), .Depth(RegCount)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_widx), .i_wdata(rf_wval),
        .i_re(accept), .i_raddr(i_src_a_index), .o_rdata(rd_a)
    );
    mieu_ram #(.Width(64), .Depth(RegCount)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_widx), .i_wdata(rf_wval),
        .i_re(accept), .i_raddr(i_src_b_index), .o_rdata(rd_b)
    );

    assign va = r_va_ok ? rd_a : '0;
    assign vb = r_vb_ok ? rd_b : '0;

    always_comb begin
        case (r_act)
            A_MULT:  mdu_op = M_MULT;
            A_DIV:   mdu_op = M_DIV;
            default: mdu_op = M_DIVU;
        endcase
    end

    mieu_mdu u_mdu (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_EXEC && is_mdu), .i_op(mdu_op),
        .i_a(va[31:0]), .i_b(vb[31:0]),
        .o_done(mdu_done), .o_hi(mdu_hi), .o_lo(mdu_lo)
    );

    always_comb begin
        a       = va[31:0];
        b       = vb[31:0];
        simm    = {{16{r_imm[15]}}, r_imm};
        jtarget = (r_pc & JumpRegionMask) | {4'd0, r_tgt, 2'b00};
        btarget = r_pc + {simm[29:0], 2'b00};
        sra_v   = 32'($signed(b) >>> r_sa);
        is_mdu  = (r_act inside {A_MULT, A_DIV, A_DIVU});
        n_npc   = r_seq;
        n_taken = 1'b0;
        n_skip  = 1'b0;
        n_wr    = 1'b0;
        n_widx  = '0;
        n_wval  = '0;
        cond    = 1'b0;
        case (r_act)
            A_J:     begin n_npc = jtarget; n_taken = 1'b1; end
            A_JAL:   begin
                n_npc = jtarget; n_taken = 1'b1;
                n_wr = 1'b1; n_widx = 5'd31; n_wval = {32'd0, r_seq};
            end
            A_JR:    begin n_npc = a; n_taken = 1'b1; end
            A_JALR:  begin
                n_npc = a; n_taken = 1'b1;
                n_wr = 1'b1; n_widx = r_rd; n_wval = {32'd0, r_seq};
            end
            A_BEQ, A_BEQL: cond = (a == b);
            A_BNE, A_BNEL: cond = (a != b);
            A_BLEZ:  cond = (a == 32'd0) || a[31];
            A_BGTZ:  cond = (a != 32'd0) && !a[31];
            A_BLTZ:  cond = a[31];
            A_BGEZ:  cond = !a[31];
            A_ADDIU: begin n_wr = 1'b1; n_widx = r_rt; n_wval = sx32(a + simm); end
            A_SLTI:  begin
                n_wr = 1'b1; n_widx = r_rt;
                n_wval = {63'd0, $signed(a) < $signed(simm)};
            end
            A_SLTIU: begin n_wr = 1'b1; n_widx = r_rt; n_wval = {63'd0, a < simm}; end
            A_ANDI:  begin n_wr = 1'b1; n_widx = r_rt; n_wval = {48'd0, a[15:0] & r_imm}; end
            A_ORI:   begin n_wr = 1'b1; n_widx = r_rt; n_wval = {32'd0, a | {16'd0, r_imm}}; end
            A_LUI:   begin n_wr = 1'b1; n_widx = r_rt; n_wval = sx32({r_imm, 16'd0}); end
            A_SLL:   begin n_wr = 1'b1; n_widx = r_rd; n_wval = sx32(b << r_sa); end
            A_SRA:   begin n_wr = 1'b1; n_widx = r_rd; n_wval = sx32(sra_v); end
            A_MOVN:  begin
                n_wr = (vb != '0); n_widx = r_rd; n_wval = va;
            end
            A_MFHI:  begin n_wr = 1'b1; n_widx = r_rd; n_wval = r_hi; end
            A_MFLO:  begin n_wr = 1'b1; n_widx = r_rd; n_wval = r_lo; end
            A_ADDU:  begin n_wr = 1'b1; n_widx = r_rd; n_wval = sx32(a + b); end
            A_SUBU:  begin n_wr = 1'b1; n_widx = r_rd; n_wval = sx32(a - b); end
            A_OR:    begin n_wr = 1'b1; n_widx = r_rd; n_wval = {32'd0, a | b}; end
            A_SLTU:  begin n_wr = 1'b1; n_widx = r_rd; n_wval = {63'd0, va < vb}; end
            A_DADDU: begin n_wr = 1'b1; n_widx = r_rd; n_wval = va + vb; end
            default: ;
        endcase
        if (r_act inside {[A_BEQ:A_BNEL]}) begin
            if (cond) begin
                n_npc   = btarget;
                n_taken = 1'b1;
            end else if (r_act inside {A_BEQL, A_BNEL}) begin
                n_skip = 1'b1;
            end
        end
        // register 0 is hardwired
        if (!n_wr || n_widx == 5'd0) begin
            n_wr   = 1'b0;
            n_widx = '0;
            n_wval = '0;
        end
    end

    // register file write: direct ops in S_EXEC, mult's rd on unit completion
    always_comb begin
        rf_we   = 1'b0;
        rf_widx = n_widx;
        rf_wval = n_wval;
        if (r_state == S_EXEC && !is_mdu) begin
            rf_we = n_wr;
        end else if (r_state == S_MDU && mdu_done && r_act == A_MULT) begin
            rf_we   = (r_rd != 5'd0);
            rf_widx = r_rd;
            rf_wval = mdu_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= '0;
            r_hi     <= '0;
            r_lo     <= '0;
        end else begin
            if (rf_we) begin
                r_rvalid[rf_widx] <= 1'b1;
            end
            case (r_state)
                S_IDLE: if (accept) r_state <= S_EXEC;
                S_EXEC: r_state <= is_mdu ? S_MDU : S_OUT;
                S_MDU: begin
                    if (mdu_done) begin
                        r_hi    <= mdu_hi;
                        r_lo    <= mdu_lo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_action;
            r_rt    <= i_src_b_index;
            r_rd    <= i_dest_index;
            r_sa    <= i_shift_amount;
            r_imm   <= i_immediate;
            r_tgt   <= i_jump_target;
            r_pc    <= i_current_pc;
            r_seq   <= i_sequential_next_pc;
            r_va_ok <= r_rvalid[i_src_a_index];
            r_vb_ok <= r_rvalid[i_src_b_index];
        end
        if (r_state == S_EXEC) begin
            r_npc   <= n_npc;
            r_taken <= n_taken;
            r_skip  <= n_skip;
            r_wr    <= n_wr;
            r_widx  <= n_widx;
            r_wval  <= n_wval;
        end else if (r_state == S_MDU && mdu_done && r_act == A_MULT) begin
            r_wr   <= (r_rd != 5'd0);
            r_widx <= r_rd;
            r_wval <= (r_rd != 5'd0) ? mdu_lo : '0;
        end
    end

    assign o_valid           = (r_state == S_OUT);
    assign o_next_pc         = r_npc;
    assign o_branch_taken    = r_taken;
    assign o_skip_delay_slot = r_skip;
    assign o_reg_written     = r_wr;
    assign o_written_index   = r_widx;
    assign o_written_value   = r_wval;
endmodule
`default_nettype wire

[sv/mieu_checker.sv]
// Port-level checks on the execute unit, bound to the top level.
`default_nettype none
module mieu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_branch_taken,
    input wire logic        o_skip_delay_slot,
    input wire logic        o_reg_written,
    input wire logic [4:0]  o_written_index,
    input wire logic [63:0] o_written_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second beat taken while one is in flight");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_written |-> o_written_index == 5'd0 && o_written_value == 64'd0)
        else $error("write fields not cleared");

    a_r0_never: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_written |-> o_written_index != 5'd0)
        else $error("write to register 0 reported");

    a_skip_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skip_delay_slot |-> !o_branch_taken)
        else $error("skip flagged on taken branch");
endmodule

bind mips64_integer_execute_unit mieu_checker u_mieu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_branch_taken(o_branch_taken),
    .o_skip_delay_slot(o_skip_delay_slot), .o_reg_written(o_reg_written),
    .o_written_index(o_written_index), .o_written_value(o_written_value)
);
`default_nettype wire
